FILE: hw/rtl/battery_mode_debounced_fsm_assert.svh
// Assertion macros for the battery mode machine.
// Included inside module bodies that use a signal named clk and a signal named rst.
`ifndef BATTERY_MODE_DEBOUNCED_FSM_ASSERT_SVH
`define BATTERY_MODE_DEBOUNCED_FSM_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BMDF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BMDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/bmdf_pkg.sv
// Shared types and constants for the battery mode machine.
// No dependencies.
package bmdf_pkg;

  typedef enum logic [3:0] {
    MODE_NORMAL      = 4'b0001,
    MODE_CHARGING    = 4'b0010,
    MODE_DISCHARGING = 4'b0100,
    MODE_LOCKED      = 4'b1000
  } mode_t;

  localparam logic [1:0] CODE_NORMAL      = 2'd0;
  localparam logic [1:0] CODE_CHARGING    = 2'd1;
  localparam logic [1:0] CODE_DISCHARGING = 2'd2;
  localparam logic [1:0] CODE_LOCKED      = 2'd3;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [2:0] REG_CHARGE_THR     = 3'd0;
  localparam logic [2:0] REG_DISCHARGE_THR  = 3'd1;
  localparam logic [2:0] REG_ENTER_CHARGE   = 3'd2;
  localparam logic [2:0] REG_ENTER_DISCHARGE = 3'd3;
  localparam logic [2:0] REG_LEAVE_CHARGE   = 3'd4;
  localparam logic [2:0] REG_LEAVE_DISCHARGE = 3'd5;

  localparam logic signed [15:0] CHARGE_THR_RESET    = 16'sd50;
  localparam logic signed [15:0] DISCHARGE_THR_RESET = -16'sd50;
  localparam logic [15:0]        DELAY_RESET         = 16'd50;

  typedef struct packed {
    logic [1:0] system_mode;
    logic       mode_changed;
  } result_t;

  function automatic logic [1:0] mode_code(input mode_t m);
    logic [1:0] code;
    unique case (m)
      MODE_NORMAL:      code = CODE_NORMAL;
      MODE_CHARGING:    code = CODE_CHARGING;
      MODE_DISCHARGING: code = CODE_DISCHARGING;
      MODE_LOCKED:      code = CODE_LOCKED;
      default:          code = CODE_LOCKED;
    endcase
    return code;
  endfunction

endpackage

FILE: hw/rtl/battery_mode_debounced_fsm.sv
// Each tick's result is registered in the output register, or in the skid entry while m_tready is low.
// Throughput: one beat per cycle while the skid entry is empty; a two-entry output buffer
// keeps s_tready high while one result waits, and state updates on each accepted beat.
// Reset (rst, synchronous, active high): mode normal, counters zero,
// registers at their default values, output buffer empty.
module battery_mode_debounced_fsm (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [15:0] pack_current, [16] charge_switch_on, [17] discharge_switch_on,
  // [18] cell_fault, [23:19] zero
  input  logic [23:0]                    s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [1:0] system_mode, [2] mode_changed, [7:3] zero
  output logic [7:0]                     m_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bmdf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bmdf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bmdf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import bmdf_pkg::*;

  logic signed [15:0] charge_thr;
  logic signed [15:0] discharge_thr;
  logic [15:0]        enter_charge_delay;
  logic [15:0]        enter_discharge_delay;
  logic [15:0]        leave_charge_delay;
  logic [15:0]        leave_discharge_delay;

  mode_t       mode;
  mode_t       mode_next;
  logic [15:0] enter_charge_count;
  logic [15:0] enter_discharge_count;
  logic [15:0] leave_charge_count;
  logic [15:0] leave_discharge_count;
  logic [15:0] enter_charge_count_next;
  logic [15:0] enter_discharge_count_next;
  logic [15:0] leave_charge_count_next;
  logic [15:0] leave_discharge_count_next;

  logic signed [15:0] pack_current;
  logic        charge_switch_on;
  logic        discharge_switch_on;
  logic        cell_fault;
  logic        accept;
  logic        cfg_write;
  logic [2:0]  cfg_index;

  logic        enter_charge_cond, enter_discharge_cond;
  logic        leave_charge_cond, leave_discharge_cond;
  logic [15:0] enter_charge_inc, enter_discharge_inc;
  logic [15:0] leave_charge_inc, leave_discharge_inc;
  logic        enter_charge_fire, enter_discharge_fire;
  logic        leave_charge_fire, leave_discharge_fire;

  result_t     result;
  result_t     out_data;
  result_t     skid_data;
  logic        out_valid;
  logic        skid_valid;

  assign pack_current        = s_tdata[15:0];
  assign charge_switch_on    = s_tdata[16];
  assign discharge_switch_on = s_tdata[17];
  assign cell_fault          = s_tdata[18];

  assign s_tready = ~skid_valid;
  assign accept   = s_tvalid & s_tready;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      charge_thr            <= CHARGE_THR_RESET;
      discharge_thr         <= DISCHARGE_THR_RESET;
      enter_charge_delay    <= DELAY_RESET;
      enter_discharge_delay <= DELAY_RESET;
      leave_charge_delay    <= DELAY_RESET;
      leave_discharge_delay <= DELAY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CHARGE_THR:      charge_thr            <= pwdata[15:0];
        REG_DISCHARGE_THR:   discharge_thr         <= pwdata[15:0];
        REG_ENTER_CHARGE:    enter_charge_delay    <= pwdata[15:0];
        REG_ENTER_DISCHARGE: enter_discharge_delay <= pwdata[15:0];
        REG_LEAVE_CHARGE:    leave_charge_delay    <= pwdata[15:0];
        REG_LEAVE_DISCHARGE: leave_discharge_delay <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_CHARGE_THR:      prdata = {{16{charge_thr[15]}}, charge_thr};
      REG_DISCHARGE_THR:   prdata = {{16{discharge_thr[15]}}, discharge_thr};
      REG_ENTER_CHARGE:    prdata = {16'd0, enter_charge_delay};
      REG_ENTER_DISCHARGE: prdata = {16'd0, enter_discharge_delay};
      REG_LEAVE_CHARGE:    prdata = {16'd0, leave_charge_delay};
      REG_LEAVE_DISCHARGE: prdata = {16'd0, leave_discharge_delay};
      default:             prdata = '0;
    endcase
  end

  // Each counter fires once its incremented value reaches the delay.
  assign enter_charge_cond    = charge_switch_on & (pack_current > charge_thr);
  assign enter_discharge_cond = discharge_switch_on & (pack_current < discharge_thr);
  assign leave_charge_cond    = charge_switch_on & (pack_current < charge_thr);
  assign leave_discharge_cond = discharge_switch_on & (pack_current > discharge_thr);

  assign enter_charge_inc    = enter_charge_count + 16'd1;
  assign enter_discharge_inc = enter_discharge_count + 16'd1;
  assign leave_charge_inc    = leave_charge_count + 16'd1;
  assign leave_discharge_inc = leave_discharge_count + 16'd1;

  assign enter_charge_fire    = enter_charge_cond & (enter_charge_inc >= enter_charge_delay);
  assign enter_discharge_fire = enter_discharge_cond &
                                (enter_discharge_inc >= enter_discharge_delay);
  assign leave_charge_fire    = leave_charge_cond & (leave_charge_inc >= leave_charge_delay);
  assign leave_discharge_fire = leave_discharge_cond &
                                (leave_discharge_inc >= leave_discharge_delay);

  always_comb begin
    mode_next                  = mode;
    enter_charge_count_next    = enter_charge_count;
    enter_discharge_count_next = enter_discharge_count;
    leave_charge_count_next    = leave_charge_count;
    leave_discharge_count_next = leave_discharge_count;
    unique case (mode)
      MODE_NORMAL: begin
        enter_charge_count_next = (enter_charge_cond & ~enter_charge_fire) ?
                                  enter_charge_inc : 16'd0;
        enter_discharge_count_next = (enter_discharge_cond & ~enter_discharge_fire) ?
                                     enter_discharge_inc : 16'd0;
        priority if (cell_fault) begin
          mode_next = MODE_LOCKED;
        end else if (enter_discharge_fire) begin
          mode_next = MODE_DISCHARGING;
        end else if (enter_charge_fire) begin
          mode_next = MODE_CHARGING;
        end
      end
      MODE_CHARGING: begin
        leave_charge_count_next = (leave_charge_cond & ~leave_charge_fire) ?
                                  leave_charge_inc : 16'd0;
        if (leave_charge_fire) begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_DISCHARGING: begin
        leave_discharge_count_next = (leave_discharge_cond & ~leave_discharge_fire) ?
                                     leave_discharge_inc : 16'd0;
        if (leave_discharge_fire) begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_LOCKED: ;
      default: mode_next = MODE_LOCKED;
    endcase
  end

  assign result.system_mode  = mode_code(mode_next);
  assign result.mode_changed = (mode_next != mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode                  <= MODE_NORMAL;
      enter_charge_count    <= '0;
      enter_discharge_count <= '0;
      leave_charge_count    <= '0;
      leave_discharge_count <= '0;
    end else if (accept) begin
      mode                  <= mode_next;
      enter_charge_count    <= enter_charge_count_next;
      enter_discharge_count <= enter_discharge_count_next;
      leave_charge_count    <= leave_charge_count_next;
      leave_discharge_count <= leave_discharge_count_next;
    end
  end

  // Output register backed by one skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (accept) begin
      skid_data <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_data.mode_changed, out_data.system_mode};

`include "battery_mode_debounced_fsm_assert.svh"

  `BMDF_ASSERT_NEXT(a_lock_sticks, mode == MODE_LOCKED, mode == MODE_LOCKED, "lock released")
  `BMDF_ASSERT_NEXT(a_fault_locks, accept && mode == MODE_NORMAL && cell_fault,
                    mode == MODE_LOCKED, "fault in normal mode did not lock")
  `BMDF_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid entry without output beat")
  `BMDF_ASSERT_NEXT(a_state_holds, !accept && !cfg_write, $stable(mode) &&
                    $stable(enter_charge_count) && $stable(leave_charge_count),
                    "state moved without an input beat")

endmodule
